// ===== hdl/integer_to_ascii_radix_top_macros.svh =====
// Assertion macros for the integer-to-ASCII block.
// Used by itoa_ctrl.sv; no other dependencies.
`ifndef INTEGER_TO_ASCII_RADIX_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ITOA_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define ITOA_ASSERT_NR(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define ITOA_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define ITOA_ASSERT_NR(lbl, clk_s, prop, msg)
`endif
`endif

// ===== hdl/itoa_pkg.sv =====
// Shared types, constants and helpers for the integer-to-ASCII block.
// No dependencies.
package itoa_pkg;

  localparam int VALUE_W   = 32;
  localparam int SPACE_W   = 7;
  localparam int CHAR_W    = 7;
  localparam int DIGITS    = VALUE_W;            // binary gives the most digits
  localparam int DIG_IDX_W = $clog2(DIGITS);
  localparam int NDIG_W    = $clog2(DIGITS + 1);

  // floor(x / 10) == (x * DEC_RECIP) >> DEC_SHIFT for every 32-bit x
  localparam logic [VALUE_W-1:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int                 DEC_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
  localparam logic [CHAR_W-1:0] CH_B     = 7'h62;

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_HEX  = 2'd2,
    OP_BIN  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic load;   // capture an accepted item
    logic step;   // produce one digit
    logic emit;   // load the next character into the output register
  } itoa_cmd_t;

  typedef struct packed {
    logic conv_done;  // current step yields the top digit
    logic emit_last;  // next character closes the run
  } itoa_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + CHAR_W'(d);
    end
    return CH_A + CHAR_W'(d - 4'd10);
  endfunction

endpackage

// ===== hdl/itoa_dp.sv =====
// Datapath: operand magnitude, digit extraction, digit buffer, output payload.
// Depends on itoa_pkg.
module itoa_dp import itoa_pkg::*; (
  input  logic                clk,
  input  itoa_cmd_t           cmd_i,
  output itoa_stat_t          stat_o,
  input  logic [1:0]          in_opcode,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [SPACE_W-1:0]  in_space,
  output logic [CHAR_W-1:0]   out_char_out,
  output logic                out_last,
  output logic                out_empty_res
);

  opcode_t              op_r;
  logic [VALUE_W-1:0]   mag_r;
  logic [3:0]           dig_r [DIGITS];
  logic [NDIG_W-1:0]    ndig_r;
  logic [DIG_IDX_W-1:0] rd_r;
  logic [1:0]           plen_r;
  logic [SPACE_W-1:0]   space_r;
  logic [SPACE_W-1:0]   count_r;
  logic [SPACE_W-1:0]   k_r;
  logic                 noroom_r;
  logic [CHAR_W-1:0]    char_r;
  logic                 last_r;
  logic                 empty_r;

  opcode_t              in_op;
  logic                 in_neg;
  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   dec_q;
  logic [3:0]           q10_lo;
  logic [3:0]           dec_rem;
  logic [VALUE_W-1:0]   step_mag;
  logic [3:0]           step_dig;
  logic [SPACE_W-1:0]   total;
  logic [SPACE_W-1:0]   count_nxt;
  logic [CHAR_W-1:0]    char_nxt;
  logic                 emit_last;

  assign in_op  = opcode_t'(in_opcode);
  assign in_neg = (in_op == OP_SDEC) && in_value[VALUE_W-1];

  // divide by ten through the reciprocal; remainder needs only the low nibble
  assign prod    = mag_r * DEC_RECIP;
  assign dec_q   = VALUE_W'(prod >> DEC_SHIFT);
  assign q10_lo  = {dec_q[0], 3'b000} + {dec_q[2:0], 1'b0};
  assign dec_rem = mag_r[3:0] - q10_lo;

  always_comb begin
    case (op_r) inside
      OP_SDEC, OP_UDEC: begin
        step_mag = dec_q;
        step_dig = dec_rem;
      end
      OP_HEX: begin
        step_mag = mag_r >> 4;
        step_dig = mag_r[3:0];
      end
      default: begin
        step_mag = mag_r >> 1;
        step_dig = {3'b000, mag_r[0]};
      end
    endcase
  end

  // characters in the text once the top digit is written
  assign total     = SPACE_W'(plen_r) + SPACE_W'(ndig_r) + SPACE_W'(1);
  assign count_nxt = noroom_r ? '0 : ((total > space_r) ? space_r : total);

  always_comb begin
    if (k_r < SPACE_W'(plen_r)) begin
      if (plen_r == 2'd1) begin
        char_nxt = CH_MINUS;
      end else if (k_r == '0) begin
        char_nxt = CH_ZERO;
      end else begin
        char_nxt = (op_r == OP_HEX) ? CH_X : CH_B;
      end
    end else begin
      char_nxt = digit_char(dig_r[rd_r]);
    end
  end

  assign emit_last = (count_r == '0) || (k_r == count_r - SPACE_W'(1));

  assign stat_o.conv_done = (step_mag == '0);
  assign stat_o.emit_last = emit_last;

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r     <= in_op;
      mag_r    <= in_neg ? (VALUE_W'(0) - in_value) : in_value;
      plen_r   <= in_neg ? 2'd1 : ((in_op == OP_HEX || in_op == OP_BIN) ? 2'd2 : 2'd0);
      noroom_r <= (in_op == OP_HEX || in_op == OP_BIN) ? (in_space < SPACE_W'(2))
                                                       : (in_space == '0);
      space_r  <= in_space;
      ndig_r   <= '0;
      k_r      <= '0;
    end
    if (cmd_i.step) begin
      dig_r[ndig_r[DIG_IDX_W-1:0]] <= step_dig;
      mag_r  <= step_mag;
      ndig_r <= ndig_r + NDIG_W'(1);
      if (stat_o.conv_done) begin
        rd_r    <= ndig_r[DIG_IDX_W-1:0];
        count_r <= count_nxt;
      end
    end
    if (cmd_i.emit) begin
      if (count_r == '0) begin
        char_r  <= '0;
        last_r  <= 1'b1;
        empty_r <= 1'b1;
      end else begin
        char_r  <= char_nxt;
        last_r  <= emit_last;
        empty_r <= 1'b0;
        k_r     <= k_r + SPACE_W'(1);
        if (k_r >= SPACE_W'(plen_r)) begin
          rd_r <= rd_r - DIG_IDX_W'(1);
        end
      end
    end
  end

  assign out_char_out  = char_r;
  assign out_last      = last_r;
  assign out_empty_res = empty_r;

endmodule

// ===== hdl/itoa_ctrl.sv =====
// Controller: sequences load, digit conversion and character output.
// Depends on itoa_pkg and integer_to_ascii_radix_top_macros.svh.
`include "integer_to_ascii_radix_top_macros.svh"
module itoa_ctrl import itoa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  itoa_stat_t stat_i,
  output itoa_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.step = 1'b1;
        if (stat_i.conv_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd_o.emit = 1'b1;
          if (stat_i.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd_o.emit | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ITOA_ASSERT(a_load_starts_conv, clk, rst_n, cmd_o.load |=> state_r == S_CONV, "load did not start conversion")
  `ITOA_ASSERT(a_last_ends_run, clk, rst_n, (cmd_o.emit && stat_i.emit_last) |=> (state_r == S_IDLE && out_valid_r), "final character did not end the run")
  `ITOA_ASSERT(a_valid_from_emit, clk, rst_n, $rose(out_valid_r) |-> $past(cmd_o.emit), "output valid rose without a character load")

endmodule

// ===== hdl/integer_to_ascii_radix_top.sv =====
// Top level of the integer-to-ASCII converter (signed/unsigned decimal, hex, binary).
// Depends on itoa_pkg, itoa_ctrl and itoa_dp.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | in_opcode[1:0], in_value[31:0], in_space[6:0]
//  result  | out_valid / out_ready| out_char_out[6:0], out_last, out_empty_res
//
// Flow: the item is taken in IDLE, then one digit per cycle (decimal up to 10, hex up
//   to 8, binary up to 32), then one character per cycle while the sink keeps up.
//   A new item is taken only in IDLE, once the last character of the run is loaded.
//   Digits go through the shared divide-by-ten / shift unit and the single output register.
// Reset: rst_n is synchronous, active low; it clears the sequencer and out_valid.
// Stalls: an out_ready held low freezes character output; the last character of a run
//   may still wait in the output register while the next item is taken.
module integer_to_ascii_radix_top import itoa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [SPACE_W-1:0] in_space,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_char_out,
  output logic               out_last,
  output logic               out_empty_res
);

  itoa_cmd_t  cmd;
  itoa_stat_t stat;

  // sequencer: IDLE -> CONV (one digit per cycle, LSB first) -> EMIT (MSB first)
  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // magnitude, digit buffer, prefix/sign selection and the output payload register
  itoa_dp u_dp (
    .clk           (clk),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_opcode     (in_opcode),
    .in_value      (in_value),
    .in_space      (in_space),
    .out_char_out  (out_char_out),
    .out_last      (out_last),
    .out_empty_res (out_empty_res)
  );

endmodule
